FILE: sv/ppr_pkg.sv
// shared types and constants of the proxy pdu reassembler
package ppr_pkg;

  localparam int BUF_BYTES   = 64;
  localparam int ADDR_W      = $clog2(BUF_BYTES);
  localparam int CNT_W       = $clog2(BUF_BYTES + 1);
  localparam int LEN_W       = 7;
  localparam int TYPE_W      = 6;
  localparam int TIMER_W     = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 32'd20000;

  typedef enum logic [1:0] {
    SAR_WHOLE  = 2'd0,
    SAR_START  = 2'd1,
    SAR_MIDDLE = 2'd2,
    SAR_END    = 2'd3
  } sar_t;

  typedef enum logic [1:0] {
    MODE_AWAIT   = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_SKIP    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK               = 3'd0,
    ST_COMPLETE_PENDING = 3'd1,
    ST_FIRST_PENDING    = 3'd2,
    ST_CONT_NO_START    = 3'd3,
    ST_LAST_NO_START    = 3'd4,
    ST_TYPE_MISMATCH    = 3'd5,
    ST_OVERFLOW         = 3'd6,
    ST_TIMEOUT          = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_ISSUE = 2'd1,
    BK_WAIT  = 2'd2
  } back_state_t;

  // one job for the back end: a status report or a message drain
  typedef struct packed {
    logic              is_drain;
    status_t           status;
    logic [TYPE_W-1:0] pdu_type;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

FILE: sv/proxy_pdu_reassembler_core.sv
// top level of the proxy pdu reassembler
//
//  channel  handshake              beat contents
//  -------  ---------------------  ------------------------------------------
//  input    push / full            req_type, data_byte, seg_first, seg_last
//  result   pop / empty            kind, status, pdu_type, out_byte, msg_len,
//                                  last_of_run
//  config   cfg_valid / cfg_ready  cfg_data (timeout_ticks, 32 bit)
//
// an input beat's status report passes through the command queue and then the
// output register before it reaches the result ports. a completed message goes
// through the command queue, then drains byte by byte, each byte taking a read
// issue and then an output register load once the result slot is free; input
// stays full until the last byte is loaded.
// reset is synchronous; no clearing pass is needed.
// a stalled result side backs up into the command queue and then into full.
module proxy_pdu_reassembler_core (
  input  logic                        clk,
  input  logic                        rst,
  // input queue side
  input  logic                        push,
  output logic                        full,
  input  logic                        req_type,
  input  logic [7:0]                  data_byte,
  input  logic                        seg_first,
  input  logic                        seg_last,
  // result queue side
  output logic                        empty,
  input  logic                        pop,
  output logic                        kind,
  output logic [2:0]                  status,
  output logic [ppr_pkg::TYPE_W-1:0]  pdu_type,
  output logic [7:0]                  out_byte,
  output logic [ppr_pkg::LEN_W-1:0]   msg_len,
  output logic                        last_of_run,
  // timeout register write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ppr_pkg::TIMER_W-1:0] cfg_data
);
  import ppr_pkg::*;

  // front to queue
  logic              q_wr;
  cmd_t              q_wr_cmd;
  logic              q_full;
  // queue to back
  logic              q_rd;
  cmd_t              q_head;
  logic              q_empty;
  // payload ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  // back tells front the store is free again
  logic              drain_done;

  // classifies each beat, keeps framing and timer state, writes payload
  ppr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .seg_first  (seg_first),
    .seg_last   (seg_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_cmd      (q_wr_cmd),
    .drain_done (drain_done),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  // at most one job per input beat goes in here
  ppr_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_cmd (q_wr_cmd),
    .rd_en  (q_rd),
    .rd_cmd (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  // message payload; entries below the fill count are the only ones read
  ppr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // expands jobs into result beats
  ppr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_rd        (q_rd),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .drain_done  (drain_done),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .status      (status),
    .pdu_type    (pdu_type),
    .out_byte    (out_byte),
    .msg_len     (msg_len),
    .last_of_run (last_of_run)
  );

endmodule

FILE: sv/ppr_ram.sv
// generic single write port ram with registered read
module ppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/ppr_cmd_queue.sv
// short command queue between the front and back ends
module ppr_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ppr_pkg::cmd_t wr_cmd,
  input  logic          rd_en,
  output ppr_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);
  import ppr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full   = (count == CNT_QW'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_QW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

FILE: sv/ppr_front.sv
// front end: framing, sequence checks, timer and payload store writes
module ppr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       req_type,
  input  logic [7:0]                 data_byte,
  input  logic                       seg_first,
  input  logic                       seg_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ppr_pkg::TIMER_W-1:0] cfg_data,
  input  logic                       q_full,
  output logic                       q_wr,
  output ppr_pkg::cmd_t              q_cmd,
  input  logic                       drain_done,
  output logic                       ram_we,
  output logic [ppr_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                 ram_wdata
);
  import ppr_pkg::*;

  logic [TIMER_W-1:0] timeout_ticks;
  logic [CNT_W-1:0]   fill_count, fill_count_next;
  logic [TYPE_W-1:0]  pending_type, pending_type_next;
  sar_t               segment_sar, segment_sar_next;
  mode_t              segment_mode, segment_mode_next;
  logic [TIMER_W-1:0] timer_count, timer_count_next;
  logic               timer_armed, timer_armed_next;
  logic               drain_busy;

  logic               accept;
  logic               pending;
  logic [TIMER_W-1:0] limit;
  logic [TIMER_W-1:0] count_inc;
  sar_t               hdr_sar;
  logic [TYPE_W-1:0]  hdr_type;
  status_t            err;

  assign cfg_ready = 1'b1;
  assign full      = q_full || drain_busy;
  assign accept    = push && !full;
  assign pending   = (fill_count != '0);
  assign limit     = (timeout_ticks == '0) ? TIMER_W'(1) : timeout_ticks;
  assign count_inc = (timer_count == '1) ? timer_count : timer_count + TIMER_W'(1);
  assign hdr_sar   = sar_t'(data_byte[7:6]);
  assign hdr_type  = data_byte[TYPE_W-1:0];
  assign ram_waddr = fill_count[ADDR_W-1:0];
  assign ram_wdata = data_byte;

  always_comb begin
    case (hdr_sar)
      SAR_WHOLE: err = pending ? ST_COMPLETE_PENDING : ST_OK;
      SAR_START: err = pending ? ST_FIRST_PENDING : ST_OK;
      default: begin
        if (!pending) begin
          err = (hdr_sar == SAR_MIDDLE) ? ST_CONT_NO_START : ST_LAST_NO_START;
        end else if (pending_type != hdr_type) begin
          err = ST_TYPE_MISMATCH;
        end else begin
          err = ST_OK;
        end
      end
    endcase
  end

  always_comb begin
    fill_count_next   = fill_count;
    pending_type_next = pending_type;
    segment_sar_next  = segment_sar;
    segment_mode_next = segment_mode;
    timer_count_next  = timer_count;
    timer_armed_next  = timer_armed;
    q_wr              = 1'b0;
    q_cmd.is_drain    = 1'b0;
    q_cmd.status      = ST_OK;
    q_cmd.pdu_type    = pending_type;
    q_cmd.len         = '0;
    ram_we            = 1'b0;

    if (accept) begin
      if (req_type) begin
        // timer tick
        if (timer_armed) begin
          if (count_inc >= limit) begin
            q_wr              = 1'b1;
            q_cmd.status      = ST_TIMEOUT;
            fill_count_next   = '0;
            timer_armed_next  = 1'b0;
            timer_count_next  = '0;
            if (segment_mode == MODE_COLLECT) begin
              segment_mode_next = MODE_SKIP;
            end
          end else begin
            timer_count_next = count_inc;
          end
        end
      end else begin
        if (seg_first) begin
          if (err != ST_OK) begin
            q_wr              = 1'b1;
            q_cmd.status      = err;
            q_cmd.pdu_type    = hdr_type;
            segment_mode_next = MODE_SKIP;
          end else begin
            segment_mode_next = MODE_COLLECT;
            segment_sar_next  = hdr_sar;
            if (hdr_sar == SAR_WHOLE || hdr_sar == SAR_START) begin
              pending_type_next = hdr_type;
            end
            if (hdr_sar == SAR_START || hdr_sar == SAR_MIDDLE) begin
              timer_armed_next = 1'b1;
              timer_count_next = '0;
            end else if (hdr_sar == SAR_END) begin
              timer_armed_next = 1'b0;
              timer_count_next = '0;
            end
          end
        end else if (segment_mode == MODE_COLLECT) begin
          if (fill_count >= CNT_W'(BUF_BYTES)) begin
            q_wr              = 1'b1;
            q_cmd.status      = ST_OVERFLOW;
            fill_count_next   = '0;
            timer_armed_next  = 1'b0;
            timer_count_next  = '0;
            segment_mode_next = MODE_SKIP;
          end else begin
            ram_we          = 1'b1;
            fill_count_next = fill_count + CNT_W'(1);
          end
        end

        if (seg_last) begin
          if (segment_mode_next == MODE_COLLECT &&
              (segment_sar_next == SAR_WHOLE || segment_sar_next == SAR_END)) begin
            q_wr            = 1'b1;
            q_cmd.is_drain  = 1'b1;
            q_cmd.pdu_type  = pending_type_next;
            q_cmd.len       = LEN_W'(fill_count_next);
            fill_count_next = '0;
          end
          segment_mode_next = MODE_AWAIT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      fill_count    <= '0;
      pending_type  <= '0;
      segment_sar   <= SAR_WHOLE;
      segment_mode  <= MODE_AWAIT;
      timer_count   <= '0;
      timer_armed   <= 1'b0;
      drain_busy    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_ticks <= cfg_data;
      end
      fill_count   <= fill_count_next;
      pending_type <= pending_type_next;
      segment_sar  <= segment_sar_next;
      segment_mode <= segment_mode_next;
      timer_count  <= timer_count_next;
      timer_armed  <= timer_armed_next;
      // store is locked until the back end has read out the message
      if (q_wr && q_cmd.is_drain) begin
        drain_busy <= 1'b1;
      end else if (drain_done) begin
        drain_busy <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/ppr_back.sv
// back end: turns queued jobs into result beats through an output register
module ppr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  ppr_pkg::cmd_t               q_head,
  output logic                        q_rd,
  output logic                        ram_re,
  output logic [ppr_pkg::ADDR_W-1:0]  ram_raddr,
  input  logic [7:0]                  ram_rdata,
  output logic                        drain_done,
  output logic                        empty,
  input  logic                        pop,
  output logic                        kind,
  output logic [2:0]                  status,
  output logic [ppr_pkg::TYPE_W-1:0]  pdu_type,
  output logic [7:0]                  out_byte,
  output logic [ppr_pkg::LEN_W-1:0]   msg_len,
  output logic                        last_of_run
);
  import ppr_pkg::*;

  back_state_t       state, state_next;
  logic [ADDR_W-1:0] idx;
  logic [TYPE_W-1:0] cur_type;
  logic [LEN_W-1:0]  cur_len;
  logic              out_valid;

  logic              slot_free;
  logic              run_end;
  logic              start_run;
  logic              load;
  logic              ld_kind;
  status_t           ld_status;
  logic [TYPE_W-1:0] ld_type;
  logic [7:0]        ld_byte;
  logic [LEN_W-1:0]  ld_len;
  logic              ld_last;

  assign slot_free = !out_valid || pop;
  assign run_end   = ((LEN_W'(idx) + LEN_W'(1)) == cur_len);
  assign start_run = !q_empty && q_head.is_drain && (q_head.len != '0);
  assign ram_raddr = idx;
  assign empty     = !out_valid;

  always_comb begin
    case (state)
      BK_IDLE:  state_next = start_run ? BK_ISSUE : BK_IDLE;
      BK_ISSUE: state_next = BK_WAIT;
      BK_WAIT: begin
        if (slot_free) begin
          state_next = run_end ? BK_IDLE : BK_ISSUE;
        end else begin
          state_next = BK_WAIT;
        end
      end
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_rd       = 1'b0;
    ram_re     = 1'b0;
    drain_done = 1'b0;
    load       = 1'b0;
    ld_kind    = 1'b0;
    ld_status  = ST_OK;
    ld_type    = cur_type;
    ld_byte    = '0;
    ld_len     = '0;
    ld_last    = 1'b1;
    case (state)
      BK_IDLE: begin
        if (start_run) begin
          q_rd = 1'b1;
        end else if (!q_empty && slot_free) begin
          // status report or empty message: a single beat
          q_rd       = 1'b1;
          load       = 1'b1;
          ld_kind    = q_head.is_drain;
          ld_status  = q_head.status;
          ld_type    = q_head.pdu_type;
          drain_done = q_head.is_drain;
        end
      end
      BK_ISSUE: begin
        ram_re = 1'b1;
      end
      BK_WAIT: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_kind    = 1'b1;
          ld_byte    = ram_rdata;
          ld_len     = cur_len;
          ld_last    = run_end;
          drain_done = run_end;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && start_run) begin
      idx      <= '0;
      cur_type <= q_head.pdu_type;
      cur_len  <= q_head.len;
    end else if (state == BK_WAIT && slot_free && !run_end) begin
      idx <= idx + ADDR_W'(1);
    end
    if (load) begin
      kind        <= ld_kind;
      status      <= ld_status;
      pdu_type    <= ld_type;
      out_byte    <= ld_byte;
      msg_len     <= ld_len;
      last_of_run <= ld_last;
    end
  end

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the proxy pdu reassembler core
`timescale 1ns / 1ps

module testbench;
  import ppr_pkg::*;

  // one link beat as the sender presents it
  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       seg_first;
    logic       seg_last;
  } link_item_t;

  // one result beat as the receiver expects it
  typedef struct packed {
    logic              kind;
    status_t           status;
    logic [TYPE_W-1:0] pdu_type;
    logic [7:0]        out_byte;
    logic [LEN_W-1:0]  msg_len;
    logic              last_of_run;
  } result_t;

  // after the last expected result the block may still be chewing on beats
  // that cause nothing (ticks, stray bytes); a result passes through the command
  // queue and the output register, so this is plenty
  localparam int SETTLE_CYCLES = 20;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic                req_type = 1'b0;
  logic [7:0]          data_byte = 8'h00;
  logic                seg_first = 1'b0;
  logic                seg_last = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic                kind;
  logic [2:0]          status;
  logic [TYPE_W-1:0]   pdu_type;
  logic [7:0]          out_byte;
  logic [LEN_W-1:0]    msg_len;
  logic                last_of_run;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TIMER_W-1:0]  cfg_data = '0;

  proxy_pdu_reassembler_core uut (.*);

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // beats waiting to be sent, and results waiting to be seen
  link_item_t link_beats [$];
  result_t    due_results [$];

  // our own copy of the reassembly state
  logic [7:0]         held_payload [BUF_BYTES];
  int                 held_count = 0;
  logic [TYPE_W-1:0]  held_type = '0;
  sar_t               open_sar = SAR_WHOLE;
  mode_t              framing = MODE_AWAIT;
  logic [TIMER_W-1:0] idle_ticks = '0;
  logic               timer_live = 1'b0;
  logic [TIMER_W-1:0] timeout_limit = TIMEOUT_RESET;

  // bookkeeping
  int mismatches = 0;
  int stim_beats = 0;
  int beats_taken = 0;
  int results_seen = 0;
  int msg_bytes = 0;
  int settings_used = 1;
  int status_seen [8];

  int send_gap = 0;
  int send_calm = 0;
  int recv_hold = 0;
  int recv_calm = 0;
  link_item_t cur_item;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s got 0x%0h expected 0x%0h",
                                results_seen, name, got, want));
  endtask

  function automatic result_t make_result(input logic k, input status_t st,
                                          input logic [TYPE_W-1:0] t,
                                          input logic [7:0] b,
                                          input logic [LEN_W-1:0] l);
    result_t r;
    r.kind = k;
    r.status = st;
    r.pdu_type = t;
    r.out_byte = b;
    r.msg_len = l;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // partial message gone: buffer empty, timer off
  function void drop_message();
    held_count = 0;
    timer_live = 1'b0;
    idle_ticks = '0;
  endfunction

  // advance the reassembly state by one accepted beat and queue what it causes
  function automatic void reassemble(input link_item_t it);
    result_t            run [0:BUF_BYTES];
    int                 n;
    logic [TIMER_W-1:0] limit;
    sar_t               sar;
    logic [TYPE_W-1:0]  typ;
    status_t            err;
    n = 0;
    if (it.req_type) begin
      // timer tick, only counts while armed; a limit of zero behaves as one
      if (timer_live) begin
        limit = (timeout_limit == '0) ? TIMER_W'(1) : timeout_limit;
        if (idle_ticks != '1) idle_ticks++;
        if (idle_ticks >= limit) begin
          run[n] = make_result(1'b0, ST_TIMEOUT, held_type, 8'h00, '0);
          n++;
          drop_message();
          if (framing == MODE_COLLECT) framing = MODE_SKIP;
        end
      end
    end else begin
      if (it.seg_first) begin
        // a header always opens a new segment, whatever was going on
        sar = sar_t'(it.data_byte[7:6]);
        typ = it.data_byte[5:0];
        err = ST_OK;
        if (sar == SAR_WHOLE) begin
          if (held_count != 0) err = ST_COMPLETE_PENDING;
        end else if (sar == SAR_START) begin
          if (held_count != 0) err = ST_FIRST_PENDING;
        end else if (held_count == 0) begin
          if (sar == SAR_MIDDLE) err = ST_CONT_NO_START;
          else err = ST_LAST_NO_START;
        end else if (held_type != typ) begin
          err = ST_TYPE_MISMATCH;
        end
        if (err != ST_OK) begin
          // rejected header reports its own type, pending data stays
          run[n] = make_result(1'b0, err, typ, 8'h00, '0);
          n++;
          framing = MODE_SKIP;
        end else begin
          framing = MODE_COLLECT;
          open_sar = sar;
          if (sar == SAR_WHOLE || sar == SAR_START) held_type = typ;
          if (sar == SAR_START || sar == SAR_MIDDLE) begin
            timer_live = 1'b1;
            idle_ticks = '0;
          end else if (sar == SAR_END) begin
            timer_live = 1'b0;
            idle_ticks = '0;
          end
        end
      end else if (framing == MODE_COLLECT) begin
        if (held_count >= BUF_BYTES) begin
          run[n] = make_result(1'b0, ST_OVERFLOW, held_type, 8'h00, '0);
          n++;
          drop_message();
          framing = MODE_SKIP;
        end else begin
          held_payload[held_count] = it.data_byte;
          held_count++;
        end
      end
      if (it.seg_last) begin
        // end of a complete or last segment drains the whole message
        if (framing == MODE_COLLECT && (open_sar == SAR_WHOLE || open_sar == SAR_END)) begin
          if (held_count == 0) begin
            run[n] = make_result(1'b1, ST_OK, held_type, 8'h00, '0);
            n++;
          end else begin
            for (int i = 0; i < held_count; i++) begin
              run[n] = make_result(1'b1, ST_OK, held_type, held_payload[i],
                                   LEN_W'(held_count));
              n++;
            end
          end
          held_count = 0;
        end
        framing = MODE_AWAIT;
      end
    end
    if (n > 0) run[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) due_results.push_back(run[i]);
  endfunction

  // sender: one beat in flight, a random pause (send_gap) after each accepted
  // beat, with occasional stretches of back-to-back beats
  always @(posedge clk) begin : drive_link
    logic busy;
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      busy = push;
      if (push && !full) begin
        reassemble(cur_item);
        beats_taken++;
        busy = 1'b0;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = $urandom_range(0, 3);
          if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(8, 30);
        end
      end else if (!push && send_gap > 0) begin
        send_gap--;
      end
      if (!busy && send_gap == 0 && link_beats.size() > 0) begin
        cur_item = link_beats.pop_front();
        req_type <= cur_item.req_type;
        data_byte <= cur_item.data_byte;
        seg_first <= cur_item.seg_first;
        seg_last <= cur_item.seg_last;
        busy = 1'b1;
      end
      push <= busy;
    end
  end

  // receiver: pop stays up while waiting, then stalls for a random hold (recv_hold) per beat
  always @(posedge clk) begin : watch_results
    result_t want;
    if (rst) begin
      pop <= 1'b0;
      recv_hold = 0;
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          want = due_results.pop_front();
          compare_field("kind", kind, want.kind);
          compare_field("status", status, want.status);
          compare_field("pdu_type", pdu_type, want.pdu_type);
          compare_field("out_byte", out_byte, want.out_byte);
          compare_field("msg_len", msg_len, want.msg_len);
          compare_field("last_of_run", last_of_run, want.last_of_run);
        end
        results_seen++;
        if (kind === 1'b1) msg_bytes++;
        else if (kind === 1'b0 && !$isunknown(status)) status_seen[status]++;
        if (recv_calm > 0) begin
          recv_calm--;
          recv_hold = 0;
        end else begin
          recv_hold = $urandom_range(0, 3);
          if ($urandom_range(0, 19) == 0) recv_calm = $urandom_range(8, 30);
        end
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      pop <= (recv_hold == 0);
    end
  end

  task automatic add_beat(input logic req, input logic [7:0] data,
                          input logic hdr, input logic fin);
    link_item_t it;
    it.req_type = req;
    it.data_byte = data;
    it.seg_first = hdr;
    it.seg_last = fin;
    link_beats.push_back(it);
    stim_beats++;
  endtask

  // ticks carry junk in the byte fields, the block must not care
  task automatic add_ticks(input int count);
    repeat (count)
      add_beat(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
  endtask

  // header plus len payload bytes; tick_odds of n slips a tick in front of
  // about one byte in n, zero means never
  task automatic add_segment(input sar_t sar, input logic [TYPE_W-1:0] typ,
                             input int len, input int tick_odds);
    add_beat(1'b0, {sar, typ}, 1'b1, len == 0);
    for (int i = 0; i < len; i++) begin
      if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1) add_ticks(1);
      add_beat(1'b0, 8'($urandom_range(0, 255)), 1'b0, i == len - 1);
    end
  endtask

  // mostly short segments, now and then a longer one
  function automatic int seg_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(9, 20);
    return $urandom_range(0, 6);
  endfunction

  // quiet gap between segments, sometimes long enough to expire a short timeout
  function automatic int gap_ticks();
    if ($urandom_range(0, 7) == 0) return $urandom_range(3, 10);
    return $urandom_range(0, 2);
  endfunction

  // mostly well-formed messages with random content, plus broken headers,
  // abandoned segments, tick runs and raw noise
  task automatic add_random_traffic(input int budget, input int broken_pct);
    int               stop_at;
    int               pick;
    int               len;
    logic             closes;
    logic [TYPE_W-1:0] typ;
    stop_at = stim_beats + budget;
    while (stim_beats < stop_at) begin
      pick = $urandom_range(0, 99);
      typ = TYPE_W'($urandom_range(0, 63));
      if (pick < broken_pct) begin
        // random header, random sar and type, possibly never closed
        closes = $urandom_range(0, 2) != 0;
        len = $urandom_range(0, 4);
        add_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1, closes && len == 0);
        for (int i = 0; i < len; i++)
          add_beat(1'b0, 8'($urandom_range(0, 255)), 1'b0, closes && i == len - 1);
      end else if (pick < broken_pct + 10) begin
        add_ticks($urandom_range(1, 8));
      end else if (pick < broken_pct + 18) begin
        repeat ($urandom_range(1, 3))
          add_beat(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end else if (pick < broken_pct + 35) begin
        add_segment(SAR_WHOLE, typ, seg_len(), 20);
        add_ticks(gap_ticks());
      end else begin
        add_segment(SAR_START, typ, seg_len(), 20);
        repeat ($urandom_range(0, 3)) begin
          add_ticks(gap_ticks());
          add_segment(SAR_MIDDLE, typ, seg_len(), 20);
        end
        add_ticks(gap_ticks());
        add_segment(SAR_END, typ, seg_len(), 20);
      end
    end
  endtask

  // block idle: nothing queued, nothing in flight, nothing owed
  task automatic wait_idle();
    @(negedge clk);
    while (link_beats.size() != 0 || push || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [TIMER_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timeout_limit = value;
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed walk through the sequence rules, reset timeout of 20000
    add_beat(1'b0, {SAR_WHOLE, 6'd0}, 1'b1, 1'b1);      // empty complete message
    add_beat(1'b0, {SAR_WHOLE, 6'd63}, 1'b1, 1'b0);     // complete, extreme bytes
    add_beat(1'b0, 8'hff, 1'b0, 1'b0);
    add_beat(1'b0, 8'h00, 1'b0, 1'b1);
    add_beat(1'b0, {SAR_START, 6'd5}, 1'b1, 1'b0);      // first, one byte pending
    add_beat(1'b0, 8'ha5, 1'b0, 1'b1);
    add_beat(1'b0, {SAR_WHOLE, 6'd7}, 1'b1, 1'b1);      // complete while pending
    add_beat(1'b0, {SAR_START, 6'd9}, 1'b1, 1'b1);      // first while pending
    add_beat(1'b0, {SAR_MIDDLE, 6'd6}, 1'b1, 1'b1);     // wrong type
    add_beat(1'b0, {SAR_MIDDLE, 6'd5}, 1'b1, 1'b0);     // good continuation
    add_beat(1'b0, 8'h5a, 1'b0, 1'b1);
    add_beat(1'b0, {SAR_END, 6'd5}, 1'b1, 1'b0);        // last, three byte message
    add_beat(1'b0, 8'h3c, 1'b0, 1'b1);
    add_beat(1'b0, {SAR_MIDDLE, 6'd9}, 1'b1, 1'b1);     // continuation with no start
    add_beat(1'b0, {SAR_END, 6'd9}, 1'b1, 1'b1);        // last with no start
    add_beat(1'b0, 8'h77, 1'b0, 1'b0);                  // stray byte, ignored
    add_beat(1'b0, {SAR_START, 6'd10}, 1'b1, 1'b1);     // first with no payload
    add_beat(1'b0, {SAR_MIDDLE, 6'd10}, 1'b1, 1'b1);    // so still nothing pending
    add_beat(1'b0, {SAR_START, 6'd2}, 1'b1, 1'b0);      // header cuts a segment short
    add_beat(1'b0, 8'h11, 1'b0, 1'b0);
    add_beat(1'b0, {SAR_WHOLE, 6'd3}, 1'b1, 1'b1);
    add_beat(1'b0, {SAR_END, 6'd2}, 1'b1, 1'b0);        // earlier byte still pending
    add_beat(1'b0, 8'h22, 1'b0, 1'b1);

    // shortest timeout: expiry in the middle of a segment, then idle tick
    write_timeout(32'd1);
    add_beat(1'b0, {SAR_START, 6'd4}, 1'b1, 1'b0);
    add_beat(1'b0, 8'h80, 1'b0, 1'b0);
    add_ticks(1);
    add_beat(1'b0, 8'h01, 1'b0, 1'b1);                  // skipped after expiry
    add_ticks(1);

    // longest timeout: a full buffer, then one byte too many on a closing beat
    write_timeout(32'hffff_ffff);
    if (held_count != 0) add_beat(1'b0, {SAR_END, held_type}, 1'b1, 1'b1);
    add_segment(SAR_START, 6'd33, 40, 0);
    add_segment(SAR_END, 6'd33, BUF_BYTES - 40, 0);
    add_segment(SAR_START, 6'd34, 40, 0);
    add_segment(SAR_MIDDLE, 6'd34, BUF_BYTES - 40 + 1, 0);
    add_random_traffic(6, 5);

    // short timeouts, where ticks matter
    write_timeout(32'd3);
    add_random_traffic(8, 20);
    write_timeout($urandom_range(2, 8));
    add_random_traffic(8, 20);
    write_timeout($urandom_range(1, 12));
    add_random_traffic(6, 15);

    wait_idle();
    $display("covered %0d link beats, %0d message bytes, %0d results, %0d timeout settings",
             beats_taken, msg_bytes, results_seen, settings_used);
    $display("status reports by code 1..7: %0d %0d %0d %0d %0d %0d %0d",
             status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5], status_seen[6], status_seen[7]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, set far beyond the slowest legal run of this stimulus
  initial begin
    #4_000_000;
    $display("timeout with %0d beats queued and %0d results owed",
             link_beats.size(), due_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/ppr_pkg.sv
sv/ppr_ram.sv
sv/ppr_cmd_queue.sv
sv/ppr_front.sv
sv/ppr_back.sv
sv/proxy_pdu_reassembler_core.sv
verif/testbench.sv
